@@ rtl/bilinear_resize_sampler_top_assert.svh @@
// Assertion macros for the bilinear resize sampler checker.
// Depends on nothing; included by the checker file.
`ifndef BILINEAR_RESIZE_SAMPLER_TOP_ASSERT_SVH
`define BILINEAR_RESIZE_SAMPLER_TOP_ASSERT_SVH

// Same-cycle implication under async active-low reset.
`define BRS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("brs: same-cycle check failed");

// Next-cycle implication under async active-low reset.
`define BRS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("brs: next-cycle check failed");

`endif

@@ rtl/brs_pkg.sv @@
// Shared types and constants for the bilinear resize sampler.
// No dependencies; used by the top level and the checker.
package brs_pkg;

  localparam int unsigned MAX_ROWS_DEF  = 256;
  localparam int unsigned MAX_COLS_DEF  = 256;
  localparam int unsigned FRAC_BITS_DEF = 8;

  localparam int unsigned OUT_SIZE_MAX = 4096;
  localparam int unsigned IN_SIZE_RST  = 256;
  localparam int unsigned OUT_SIZE_RST = 256;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned SRC_W   = 8;
  localparam int unsigned DST_W   = 12;
  localparam int unsigned RES_W   = 16;
  localparam int unsigned ISZ_W   = 9;
  localparam int unsigned OSZ_W   = 13;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned CFG_D_W = 13;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_IN_HEIGHT  = 2'd0,
    CFG_IN_WIDTH   = 2'd1,
    CFG_OUT_HEIGHT = 2'd2,
    CFG_OUT_WIDTH  = 2'd3
  } cfg_idx_e;

endpackage

@@ rtl/brs_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies; holds the source plane.
module brs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/brs_divider.sv @@
// Restoring divider, one quotient bit per cycle.
// No dependencies; shared by both axes of the sampler.
module brs_divider #(
  parameter int unsigned DEN_W = 12,
  parameter int unsigned QUO_W = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DEN_W+QUO_W-1:0] num_i,
  input  logic [DEN_W-1:0]       den_i,
  output logic                   done_o,
  output logic [QUO_W-1:0]       quo_o,
  output logic [DEN_W-1:0]       rem_o
);

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= num_i[DEN_W+QUO_W-1:QUO_W];
      quo_q  <= num_i[QUO_W-1:0];
      cnt_q  <= CNT_W'(QUO_W);
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], ge};
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/bilinear_resize_sampler_top.sv @@
// Top level of the corner-aligned bilinear resize sampler.
// Depends on brs_pkg, brs_ram and brs_divider.
//
//  channel | handshake                       | payload
//  command | start && !busy                  | command, src_row/col, pixel_in, dst_row/col
//  result  | result_valid_o, one-cycle strobe| pixel_out, coord_error
//  config  | cfg_valid_i && cfg_ready_o      | cfg_index_i, cfg_data_i
//
// A load writes the plane store and leaves busy low. An out-of-range sample
// returns its result in the next cycle with busy low. A valid sample holds
// busy while the shared divider finds each axis position, one quotient bit per
// cycle, then while the four neighbors are read over the single plane-store
// port, each with a row- and a column-weight multiply. Reset loads the size
// registers; the plane store is not cleared. The receiver cannot stall.
module bilinear_resize_sampler_top #(
  parameter int unsigned MAX_ROWS  = brs_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS  = brs_pkg::MAX_COLS_DEF,
  parameter int unsigned FRAC_BITS = brs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command_i,
  input  logic [brs_pkg::SRC_W-1:0]   src_row_i,
  input  logic [brs_pkg::SRC_W-1:0]   src_col_i,
  input  logic [brs_pkg::PIX_W-1:0]   pixel_in_i,
  input  logic [brs_pkg::DST_W-1:0]   dst_row_i,
  input  logic [brs_pkg::DST_W-1:0]   dst_col_i,
  output logic                        result_valid_o,
  output logic [brs_pkg::RES_W-1:0]   pixel_out_o,
  output logic                        coord_error_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [brs_pkg::CFG_A_W-1:0] cfg_index_i,
  input  logic [brs_pkg::CFG_D_W-1:0] cfg_data_i
);
  import brs_pkg::*;

  localparam int unsigned RB    = $clog2(MAX_ROWS);
  localparam int unsigned CB    = $clog2(MAX_COLS);
  localparam int unsigned IB    = (RB > CB) ? RB : CB;
  localparam int unsigned RSW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CSW   = $clog2(MAX_COLS + 1);
  localparam int unsigned AW    = $clog2(MAX_ROWS * MAX_COLS);
  localparam int unsigned QW    = IB + FRAC_BITS;
  localparam int unsigned MW    = DST_W + IB;
  localparam int unsigned NW    = DST_W + QW;
  localparam int unsigned WW    = FRAC_BITS + 1;
  localparam int unsigned P1W   = PIX_W + WW;
  localparam int unsigned P2W   = P1W + WW;
  localparam int unsigned SHIFT = 2 * FRAC_BITS - 8;
  localparam int unsigned IH_RST = (IN_SIZE_RST > MAX_ROWS) ? MAX_ROWS : IN_SIZE_RST;
  localparam int unsigned IW_RST = (IN_SIZE_RST > MAX_COLS) ? MAX_COLS : IN_SIZE_RST;
  localparam logic [WW-1:0]  W_ONE     = WW'(2 ** FRAC_BITS);
  localparam logic [P2W-1:0] ROUND_ADD = P2W'((2 ** SHIFT) / 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_WAIT,
    S_RD,
    S_MULY,
    S_MULX
  } state_e;

  state_e               state_q;
  logic                 axis_q;
  logic [1:0]           nb_q;
  logic [DST_W-1:0]     dr_q, dc_q;
  logic [NW-1:0]        numf_q;
  logic [DST_W-1:0]     den_q;
  logic [IB-1:0]        y0_q, y1_q, x0_q, x1_q;
  logic [FRAC_BITS-1:0] fy_q, fx_q;
  logic [P1W-1:0]       prod1_q;
  logic [P2W-1:0]       acc_q;
  logic                 res_valid_q;
  logic [RES_W-1:0]     res_pix_q;
  logic                 res_err_q;

  logic [RSW-1:0]   ih_q;
  logic [CSW-1:0]   iw_q;
  logic [OSZ_W-1:0] oh_q, ow_q;
  logic [RSW-1:0]   ih_d;
  logic [CSW-1:0]   iw_d;
  logic [OSZ_W-1:0] oh_d, ow_d;

  logic                 accept;
  logic                 load_ok;
  logic                 out_range;
  logic [DST_W-1:0]     dst_sel;
  logic [IB-1:0]        insz_m1;
  logic [OSZ_W-1:0]     outsz_sel;
  logic [MW-1:0]        num_prod;
  logic                 div_start;
  logic                 div_done;
  logic [QW-1:0]        div_quo;
  logic [DST_W-1:0]     div_rem;
  logic [IB-1:0]        q_int;
  logic [FRAC_BITS-1:0] q_frac;
  logic                 den_zero;
  logic                 rem_nz;
  logic [IB-1:0]        rd_row, rd_col;
  logic [AW-1:0]        rd_addr, ld_addr, ram_addr;
  logic                 ram_we;
  logic [PIX_W-1:0]     ram_rdata;
  logic [WW-1:0]        wy, wx;
  logic [P2W-1:0]       prod2;
  logic [P2W-1:0]       sum_d;
  logic [P2W-1:0]       rounded;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign load_ok     = (32'(src_row_i) < MAX_ROWS) && (32'(src_col_i) < MAX_COLS);
  assign out_range   = ({1'b0, dst_row_i} >= oh_q) || ({1'b0, dst_col_i} >= ow_q);

  always_comb begin
    ih_d = RSW'(cfg_data_i[ISZ_W-1:0]);
    if (cfg_data_i[ISZ_W-1:0] == '0) begin
      ih_d = RSW'(1);
    end else if (32'(cfg_data_i[ISZ_W-1:0]) > MAX_ROWS) begin
      ih_d = RSW'(MAX_ROWS);
    end
    iw_d = CSW'(cfg_data_i[ISZ_W-1:0]);
    if (cfg_data_i[ISZ_W-1:0] == '0) begin
      iw_d = CSW'(1);
    end else if (32'(cfg_data_i[ISZ_W-1:0]) > MAX_COLS) begin
      iw_d = CSW'(MAX_COLS);
    end
    oh_d = cfg_data_i;
    if (cfg_data_i == '0) begin
      oh_d = OSZ_W'(1);
    end else if (32'(cfg_data_i) > OUT_SIZE_MAX) begin
      oh_d = OSZ_W'(OUT_SIZE_MAX);
    end
    ow_d = oh_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ih_q <= RSW'(IH_RST);
      iw_q <= CSW'(IW_RST);
      oh_q <= OSZ_W'(OUT_SIZE_RST);
      ow_q <= OSZ_W'(OUT_SIZE_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IN_HEIGHT:  ih_q <= ih_d;
        CFG_IN_WIDTH:   iw_q <= iw_d;
        CFG_OUT_HEIGHT: oh_q <= oh_d;
        CFG_OUT_WIDTH:  ow_q <= ow_d;
        default: ;
      endcase
    end
  end

  assign dst_sel   = axis_q ? dc_q : dr_q;
  assign insz_m1   = axis_q ? IB'(iw_q - CSW'(1)) : IB'(ih_q - RSW'(1));
  assign outsz_sel = axis_q ? ow_q : oh_q;
  assign num_prod  = MW'(dst_sel) * MW'(insz_m1);

  assign div_start = (state_q == S_DIV);

  brs_divider #(
    .DEN_W (DST_W),
    .QUO_W (QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (numf_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign den_zero = (den_q == '0);
  assign q_int    = den_zero ? '0 : div_quo[QW-1:FRAC_BITS];
  assign q_frac   = den_zero ? '0 : div_quo[FRAC_BITS-1:0];
  assign rem_nz   = !den_zero && ((q_frac != '0) || (div_rem != '0));

  assign rd_row  = nb_q[1] ? y1_q : y0_q;
  assign rd_col  = nb_q[0] ? x1_q : x0_q;
  assign rd_addr = AW'(rd_row) * AW'(MAX_COLS) + AW'(rd_col);
  assign ld_addr = AW'(32'(src_row_i)) * AW'(MAX_COLS) + AW'(32'(src_col_i));
  assign ram_we   = accept && (command_i == CMD_LOAD) && load_ok;
  assign ram_addr = busy ? rd_addr : ld_addr;

  brs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_ROWS * MAX_COLS)
  ) u_plane (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (pixel_in_i),
    .rdata_o (ram_rdata)
  );

  assign wy      = nb_q[1] ? WW'(fy_q) : (W_ONE - WW'(fy_q));
  assign wx      = nb_q[0] ? WW'(fx_q) : (W_ONE - WW'(fx_q));
  assign prod2   = P2W'(prod1_q) * P2W'(wx);
  assign sum_d   = acc_q + prod2;
  assign rounded = (sum_d + ROUND_ADD) >> SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      nb_q        <= '0;
      dr_q        <= '0;
      dc_q        <= '0;
      numf_q      <= '0;
      den_q       <= '0;
      y0_q        <= '0;
      y1_q        <= '0;
      x0_q        <= '0;
      x1_q        <= '0;
      fy_q        <= '0;
      fx_q        <= '0;
      prod1_q     <= '0;
      acc_q       <= '0;
      res_valid_q <= 1'b0;
      res_pix_q   <= '0;
      res_err_q   <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && (command_i == CMD_SAMPLE)) begin
            dr_q   <= dst_row_i;
            dc_q   <= dst_col_i;
            axis_q <= 1'b0;
            acc_q  <= '0;
            if (out_range) begin
              res_valid_q <= 1'b1;
              res_pix_q   <= '0;
              res_err_q   <= 1'b1;
            end else begin
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          numf_q  <= {num_prod, {FRAC_BITS{1'b0}}};
          den_q   <= DST_W'(outsz_sel - OSZ_W'(1));
          state_q <= S_DIV;
        end
        S_DIV: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            if (!axis_q) begin
              y0_q    <= q_int;
              y1_q    <= q_int + IB'(rem_nz);
              fy_q    <= q_frac;
              axis_q  <= 1'b1;
              state_q <= S_MUL;
            end else begin
              x0_q    <= q_int;
              x1_q    <= q_int + IB'(rem_nz);
              fx_q    <= q_frac;
              nb_q    <= '0;
              state_q <= S_RD;
            end
          end
        end
        S_RD: begin
          state_q <= S_MULY;
        end
        S_MULY: begin
          prod1_q <= P1W'(ram_rdata) * P1W'(wy);
          state_q <= S_MULX;
        end
        S_MULX: begin
          acc_q <= sum_d;
          if (nb_q == 2'd3) begin
            res_valid_q <= 1'b1;
            res_pix_q   <= rounded[RES_W-1:0];
            res_err_q   <= 1'b0;
            state_q     <= S_IDLE;
          end else begin
            nb_q    <= nb_q + 2'd1;
            state_q <= S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign pixel_out_o    = res_pix_q;
  assign coord_error_o  = res_err_q;

endmodule

@@ rtl/brs_checker.sv @@
// Port-level checks for the bilinear resize sampler, bound to the top level.
// Depends on brs_pkg and bilinear_resize_sampler_top_assert.svh.
`include "bilinear_resize_sampler_top_assert.svh"

module brs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_i,
  input logic                      command_i,
  input logic                      result_valid_i,
  input logic [brs_pkg::RES_W-1:0] pixel_out_i,
  input logic                      coord_error_i
);
  import brs_pkg::*;

  logic load_acc;

  assign load_acc = start_i && !busy_i && (command_i == CMD_LOAD);

  `BRS_ASSERT_NXT(a_load_no_busy, clk_i, rst_ni, load_acc, !busy_i)
  `BRS_ASSERT_NXT(a_load_no_result, clk_i, rst_ni, load_acc, !result_valid_i)
  `BRS_ASSERT_IMP(a_result_idle, clk_i, rst_ni, result_valid_i, !busy_i)
  `BRS_ASSERT_IMP(a_busy_ends_result, clk_i, rst_ni, $fell(busy_i), result_valid_i)
  `BRS_ASSERT_IMP(a_error_zero, clk_i, rst_ni, result_valid_i && coord_error_i, pixel_out_i == '0)

endmodule

bind bilinear_resize_sampler_top brs_checker u_brs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start),
  .busy_i         (busy),
  .command_i      (command_i),
  .result_valid_i (result_valid_o),
  .pixel_out_i    (pixel_out_o),
  .coord_error_i  (coord_error_o)
);
